>>> rtl/core/segx_pkg.sv
// Package for the segment intersection core: widths, word types.
package segx_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int T_FRAC         = 24;

   typedef struct packed {
      logic signed [COORD_BITS_DEF-1:0] a_start_x;
      logic signed [COORD_BITS_DEF-1:0] a_start_y;
      logic signed [COORD_BITS_DEF-1:0] a_end_x;
      logic signed [COORD_BITS_DEF-1:0] a_end_y;
      logic signed [COORD_BITS_DEF-1:0] b_start_x;
      logic signed [COORD_BITS_DEF-1:0] b_start_y;
      logic signed [COORD_BITS_DEF-1:0] b_end_x;
      logic signed [COORD_BITS_DEF-1:0] b_end_y;
   } req_type;

   typedef struct packed {
      logic                             hit;
      logic signed [COORD_BITS_DEF-1:0] cross_x;
      logic signed [COORD_BITS_DEF-1:0] cross_y;
   } rsp_type;

endpackage

>>> rtl/core/segment_intersection_core.sv
// Segment intersection core: pipelined cross products, divider and point.
// Throughput: one word per cycle while rsp is not stalled; the 24 division steps are pipeline stages.
// A stall on rsp freezes the whole pipe and holds req_ready low until it clears.
// Reset clears the valid bits only; data registers are not reset.
module segment_intersection_core import segx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int CW = COORD_BITS_DEF;
   localparam int DW = 2*CW + 4;      // cross product width
   localparam int NS = T_FRAC + 6;

   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   logic [NS-1:0] vld_ff;

   // stage 1: differences
   logic signed [CW:0] s1x_ff, s1y_ff, s2x_ff, s2y_ff, wx_ff, wy_ff;
   logic signed [CW-1:0] ax_ff1, ay_ff1;
   // stage 2: products
   logic signed [DW-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [CW:0] s1x_ff2, s1y_ff2;
   logic signed [CW-1:0] ax_ff2, ay_ff2;
   // stage 3: d, sn, tn
   logic signed [DW-1:0] d_ff, sn_ff, tn_ff;
   logic signed [CW:0] s1x_ff3, s1y_ff3;
   logic signed [CW-1:0] ax_ff3, ay_ff3;
   // stage 4: hit test, magnitudes
   logic [DW-1:0] num_ff, den_ff;
   logic hit_ff4, eq_ff4;
   logic signed [CW:0] s1x_ff4, s1y_ff4;
   logic signed [CW-1:0] ax_ff4, ay_ff4;
   // division pipe
   logic [DW-1:0] rem_ff [T_FRAC], dd_ff [T_FRAC];
   logic [T_FRAC:0] q_ff [T_FRAC];
   logic hp_ff [T_FRAC], ep_ff [T_FRAC];
   logic signed [CW:0] sxp_ff [T_FRAC], syp_ff [T_FRAC];
   logic signed [CW-1:0] axp_ff [T_FRAC], ayp_ff [T_FRAC];
   // stage products t*s1
   logic signed [CW+T_FRAC+2:0] px_ff, py_ff;
   logic hit_ff5;
   logic signed [CW-1:0] ax_ff5, ay_ff5;
   rsp_type rsp_ff;

   function automatic logic inunit(logic signed [DW-1:0] n, logic signed [DW-1:0] d);
      logic [DW-1:0] mn, md;
      mn = n[DW-1] ? DW'(-n) : n;
      md = d[DW-1] ? DW'(-d) : d;
      return !(n != '0 && (n[DW-1] != d[DW-1])) && (mn <= md);
   endfunction

   logic [DW-1:0] rem_in [T_FRAC];
   logic [T_FRAC:0] q_in [T_FRAC];
   genvar g;
   generate
      for (g = 0; g < T_FRAC; g++) begin : g_div
         segx_div_stage #(.DW(DW)) u_step (
            .rem_i (g == 0 ? num_ff : rem_ff[(g == 0) ? 0 : g-1]),
            .den_i (g == 0 ? den_ff : dd_ff[(g == 0) ? 0 : g-1]),
            .q_i   (g == 0 ? '0 : q_ff[(g == 0) ? 0 : g-1]),
            .rem_o (rem_in[g]),
            .q_o   (q_in[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < T_FRAC; i++) begin
            rem_ff[i] <= rem_in[i];
            q_ff[i]   <= q_in[i];
         end
         dd_ff[0] <= den_ff; hp_ff[0] <= hit_ff4; ep_ff[0] <= eq_ff4;
         sxp_ff[0] <= s1x_ff4; syp_ff[0] <= s1y_ff4;
         axp_ff[0] <= ax_ff4; ayp_ff[0] <= ay_ff4;
         for (int i = 1; i < T_FRAC; i++) begin
            dd_ff[i] <= dd_ff[i-1]; hp_ff[i] <= hp_ff[i-1]; ep_ff[i] <= ep_ff[i-1];
            sxp_ff[i] <= sxp_ff[i-1]; syp_ff[i] <= syp_ff[i-1];
            axp_ff[i] <= axp_ff[i-1]; ayp_ff[i] <= ayp_ff[i-1];
         end
      end
   end

   logic [T_FRAC:0] tq;
   assign tq = ep_ff[T_FRAC-1] ? (T_FRAC+1)'(1) << T_FRAC : q_ff[T_FRAC-1];

   logic signed [CW+T_FRAC+2:0] px_in, py_in;
   assign px_in = $signed({1'b0, tq}) * sxp_ff[T_FRAC-1];
   assign py_in = $signed({1'b0, tq}) * syp_ff[T_FRAC-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff1 <= req_data.a_start_x; ay_ff1 <= req_data.a_start_y;
         s1x_ff <= (CW+1)'(req_data.a_end_x) - (CW+1)'(req_data.a_start_x);
         s1y_ff <= (CW+1)'(req_data.a_end_y) - (CW+1)'(req_data.a_start_y);
         s2x_ff <= (CW+1)'(req_data.b_end_x) - (CW+1)'(req_data.b_start_x);
         s2y_ff <= (CW+1)'(req_data.b_end_y) - (CW+1)'(req_data.b_start_y);
         wx_ff  <= (CW+1)'(req_data.a_start_x) - (CW+1)'(req_data.b_start_x);
         wy_ff  <= (CW+1)'(req_data.a_start_y) - (CW+1)'(req_data.b_start_y);

         p0_ff <= DW'(s1x_ff * s2y_ff); p1_ff <= DW'(s2x_ff * s1y_ff);
         p2_ff <= DW'(s1x_ff * wy_ff);  p3_ff <= DW'(s1y_ff * wx_ff);
         p4_ff <= DW'(s2x_ff * wy_ff);  p5_ff <= DW'(s2y_ff * wx_ff);
         s1x_ff2 <= s1x_ff; s1y_ff2 <= s1y_ff; ax_ff2 <= ax_ff1; ay_ff2 <= ay_ff1;

         d_ff <= p0_ff - p1_ff; sn_ff <= p2_ff - p3_ff; tn_ff <= p4_ff - p5_ff;
         s1x_ff3 <= s1x_ff2; s1y_ff3 <= s1y_ff2; ax_ff3 <= ax_ff2; ay_ff3 <= ay_ff2;

         num_ff  <= tn_ff[DW-1] ? DW'(-tn_ff) : tn_ff;
         den_ff  <= d_ff[DW-1] ? DW'(-d_ff) : d_ff;
         hit_ff4 <= (d_ff != '0) && inunit(sn_ff, d_ff) && inunit(tn_ff, d_ff);
         eq_ff4  <= (tn_ff == d_ff) || (tn_ff == DW'(-d_ff));
         s1x_ff4 <= s1x_ff3; s1y_ff4 <= s1y_ff3; ax_ff4 <= ax_ff3; ay_ff4 <= ay_ff3;

         px_ff <= px_in; py_ff <= py_in; hit_ff5 <= hp_ff[T_FRAC-1];
         ax_ff5 <= axp_ff[T_FRAC-1]; ay_ff5 <= ayp_ff[T_FRAC-1];

         // arithmetic shift is floor division by 2^T_FRAC
         rsp_ff.hit     <= hit_ff5;
         rsp_ff.cross_x <= hit_ff5 ? CW'(ax_ff5 + CW'(px_ff >>> T_FRAC)) : '0;
         rsp_ff.cross_y <= hit_ff5 ? CW'(ay_ff5 + CW'(py_ff >>> T_FRAC)) : '0;
      end
   end

   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = rsp_ff;

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.cross_x == '0 && rsp_data.cross_y == '0)
      else $error("miss with nonzero point");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipe stalled with empty output");
endmodule

>>> rtl/core/segx_div_stage.sv
// One restoring division step of the pipelined t quotient.
module segx_div_stage import segx_pkg::*; #(
   parameter int DW = 52
) (
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   input  logic [T_FRAC:0] q_i,
   output logic [DW-1:0] rem_o,
   output logic [T_FRAC:0] q_o
);
   logic [DW:0] sh;
   always_comb begin
      sh = {rem_i, 1'b0};
      if (sh >= {1'b0, den_i}) begin
         rem_o = DW'(sh - {1'b0, den_i});
         q_o   = {q_i[T_FRAC-1:0], 1'b1};
      end else begin
         rem_o = sh[DW-1:0];
         q_o   = {q_i[T_FRAC-1:0], 1'b0};
      end
   end
endmodule
